// ----- rtl/core/lr4_pkg.sv -----
// ----------------------------------------------------------------------------
// lr4_pkg
// Shared types and constants of the fourth-order lowpass core: coefficient
// register codes, coefficient bank type and datapath control group.
// ----------------------------------------------------------------------------
package lr4_pkg;

  localparam int CHANNELS_DEF       = 8;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 26;

  localparam int COEF_W    = 32;
  localparam int NUM_COEFS = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CHAN_W    = 3;
  localparam int RES_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A0 = 3'd0,
    REG_A1 = 3'd1,
    REG_A2 = 3'd2,
    REG_B1 = 3'd3,
    REG_B2 = 3'd4,
    REG_B3 = 3'd5,
    REG_B4 = 3'd6
  } coef_idx_t;

  typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_vec_t;

  typedef struct packed {
    logic m_vld;
    logic m_ph;
    logic p_vld;
    logic p_ph;
  } mac_ctl_t;

endpackage

// ----- rtl/core/lr4_mac.sv -----
// ----------------------------------------------------------------------------
// lr4_mac
// Four-lane multiply-accumulate: two passes per sample, then round half up
// and saturate the Q-format sum to a sample.
// ----------------------------------------------------------------------------
module lr4_mac #(
  parameter int SAMPLE_BITS    = lr4_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = lr4_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  lr4_pkg::mac_ctl_t             ctl,
  input  lr4_pkg::coef_vec_t            coef,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic [8*SAMPLE_BITS-1:0]      hist,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = lr4_pkg::COEF_W;
  localparam int OW = SB + 1;
  localparam int PW = CW + OW;
  localparam int AW = PW + 3;
  localparam int F  = COEF_FRAC_BITS;

  localparam logic signed [AW:0] RND  = {{(AW+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [AW:0] SMAX = {{(AW+2-SB){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [AW:0] SMIN = {{(AW+2-SB){1'b1}}, {(SB-1){1'b0}}};

  logic signed [SB-1:0] xs [4];
  logic signed [SB-1:0] ys [4];
  logic signed [OW-1:0] opnd [4];
  logic signed [CW-1:0] cf   [4];
  logic signed [PW-1:0] pr   [4];
  logic signed [AW-1:0] s_pos;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] fin;
  logic signed [AW:0]   rnd;
  logic signed [AW:0]   q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xs[i] = hist[i*SB +: SB];
      ys[i] = hist[(i+4)*SB +: SB];
    end
  end

  always_comb begin
    if (ctl.m_ph) begin
      opnd[0] = OW'(ys[1]);
      opnd[1] = OW'(ys[2]);
      opnd[2] = OW'(ys[3]);
      opnd[3] = '0;
      cf[0]   = coef[lr4_pkg::REG_B2];
      cf[1]   = coef[lr4_pkg::REG_B3];
      cf[2]   = coef[lr4_pkg::REG_B4];
      cf[3]   = '0;
    end else begin
      opnd[0] = OW'(x) + OW'(xs[3]);
      opnd[1] = OW'(xs[0]) + OW'(xs[2]);
      opnd[2] = OW'(xs[1]);
      opnd[3] = OW'(ys[0]);
      cf[0]   = coef[lr4_pkg::REG_A0];
      cf[1]   = coef[lr4_pkg::REG_A1];
      cf[2]   = coef[lr4_pkg::REG_A2];
      cf[3]   = coef[lr4_pkg::REG_B1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.m_vld) begin
      for (int i = 0; i < 4; i++) begin
        pr[i] <= PW'(cf[i]) * PW'(opnd[i]);
      end
    end
  end

  assign s_pos = AW'(pr[0]) + AW'(pr[1]) + AW'(pr[2]);

  always_ff @(posedge clk) begin
    if (ctl.p_vld && !ctl.p_ph) begin
      acc <= s_pos - AW'(pr[3]);
    end
    if (ctl.p_vld && ctl.p_ph) begin
      fin <= acc - s_pos - AW'(pr[3]);
    end
  end

  always_comb begin
    rnd = (AW+1)'(fin) + RND;
    q   = rnd >>> F;
    if (q > SMAX) begin
      y = SMAX[SB-1:0];
    end else if (q < SMIN) begin
      y = SMIN[SB-1:0];
    end else begin
      y = q[SB-1:0];
    end
  end

endmodule

// ----- rtl/core/linkwitz_riley4_lowpass_iir_core.sv -----
// ----------------------------------------------------------------------------
// linkwitz_riley4_lowpass_iir_core
// Multichannel fourth-order direct-form lowpass with per-channel history
// memory and a small result queue.
// ----------------------------------------------------------------------------
// Samples of different channels overlap: the four multiplier lanes take two
// passes per sample, and a new sample is accepted once the previous one has
// finished its first pass and the result queue has room for every sample in
// flight; a sample of a channel still in flight waits until that channel's
// history is written back. From accept a sample passes the multiply and
// product stages, each in two passes, and the final stage, which pushes its
// result into the output queue. The history memory holds one word per
// channel (four past inputs, four past outputs), read on accept and written
// back at the end; a valid bit per channel makes an unwritten entry read as
// zero, so reset needs no clearing pass. Channels at or above CHANNELS return
// zero and leave all history untouched.
module linkwitz_riley4_lowpass_iir_core #(
  parameter int CHANNELS       = lr4_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS    = lr4_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = lr4_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lr4_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lr4_pkg::COEF_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lr4_pkg::CHAN_W-1:0]         chan_in,
  input  logic signed [SAMPLE_BITS-1:0]      sample_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lr4_pkg::CHAN_W-1:0]         chan_out,
  output logic signed [SAMPLE_BITS-1:0]      sample_out
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CHW   = lr4_pkg::CHAN_W;
  localparam int MW    = 8 * SB;
  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW    = (AW > CHW) ? AW : CHW;
  localparam int DEPTH = lr4_pkg::RES_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [CHW-1:0]  chan;
    logic            bad;
    logic [4*SB-1:0] xw;
    logic [3*SB-1:0] yh;
  } ctx_t;

  lr4_pkg::coef_vec_t coef;

  logic [MW-1:0]      mem [CHANNELS];
  logic [CHANNELS-1:0] ent_vld;
  logic [MW-1:0]      rdata;
  logic               rd_hit;
  logic [MW-1:0]      hist;

  logic               m_vld;
  logic               m_ph;
  logic [CHW-1:0]     m_chan;
  logic               m_bad;
  logic signed [SB-1:0] m_x;
  logic               p_vld;
  logic               p_ph;
  ctx_t               p_ctx;
  logic               f_vld;
  ctx_t               f_ctx;

  lr4_pkg::mac_ctl_t  ctl;
  logic signed [SB-1:0] y;

  logic [IW-1:0]      in_ext;
  logic [AW-1:0]      in_addr;
  logic               in_bad;
  logic [IW-1:0]      f_ext;
  logic [AW-1:0]      f_addr;
  logic               hazard;
  logic [1:0]         inflight;
  logic               credit;
  logic               accept;
  logic               wr_en;

  logic [CHW-1:0]     q_chan [DEPTH];
  logic [SB-1:0]      q_smp  [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   cnt;
  logic               push;
  logic               pop;

  // coefficient bank
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_we && cfg_index <= lr4_pkg::REG_B4) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // input admission
  assign in_ext   = IW'(chan_in);
  assign in_addr  = in_ext[AW-1:0];
  assign in_bad   = 32'(chan_in) >= CHANNELS;
  assign hazard   = (m_vld && m_chan == chan_in) ||
                    (p_vld && p_ctx.chan == chan_in) ||
                    (f_vld && f_ctx.chan == chan_in);
  assign inflight = 2'(m_vld) + 2'(p_vld && p_ph) + 2'(f_vld);
  assign credit   = ((CNT_W+1)'(inflight) + (CNT_W+1)'(cnt)) < (CNT_W+1)'(DEPTH);
  assign in_stall = (m_vld && !m_ph) || !credit || hazard;
  assign accept   = in_valid && !in_stall;

  // history memory
  assign f_ext  = IW'(f_ctx.chan);
  assign f_addr = f_ext[AW-1:0];
  assign wr_en  = f_vld && !f_ctx.bad;

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[in_addr];
    end
    if (wr_en) begin
      mem[f_addr] <= {f_ctx.yh, y, f_ctx.xw};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (wr_en) begin
      ent_vld[f_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_hit <= ent_vld[in_addr];
      m_chan <= chan_in;
      m_bad  <= in_bad;
      m_x    <= sample_in;
    end
  end

  assign hist = rd_hit ? rdata : '0;

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      m_ph  <= 1'b0;
      p_vld <= 1'b0;
      p_ph  <= 1'b0;
      f_vld <= 1'b0;
    end else begin
      if (accept) begin
        m_vld <= 1'b1;
        m_ph  <= 1'b0;
      end else if (m_vld && m_ph) begin
        m_vld <= 1'b0;
      end else if (m_vld) begin
        m_ph  <= 1'b1;
      end
      p_vld <= m_vld;
      p_ph  <= m_ph;
      f_vld <= p_vld && p_ph;
    end
  end

  always_ff @(posedge clk) begin
    if (m_vld && !m_ph) begin
      p_ctx.chan <= m_chan;
      p_ctx.bad  <= m_bad;
      p_ctx.xw   <= {hist[3*SB-1:0], m_x};
      p_ctx.yh   <= hist[7*SB-1:4*SB];
    end
    if (p_vld && p_ph) begin
      f_ctx <= p_ctx;
    end
  end

  assign ctl.m_vld = m_vld;
  assign ctl.m_ph  = m_ph;
  assign ctl.p_vld = p_vld;
  assign ctl.p_ph  = p_ph;

  lr4_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .coef (coef),
    .x    (m_x),
    .hist (hist),
    .y    (y)
  );

  // result queue
  assign push = f_vld;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      q_chan[wr_ptr] <= f_ctx.chan;
      q_smp[wr_ptr]  <= f_ctx.bad ? '0 : y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign out_valid  = cnt != '0;
  assign chan_out   = q_chan[rd_ptr];
  assign sample_out = q_smp[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == CNT_W'(DEPTH)) |-> !push)
    else $error("result queue overrun");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en) |-> (chan_in != f_ctx.chan))
    else $error("history read while same channel is written back");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("pushed beat not offered");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    ((CNT_W+1)'(inflight) + (CNT_W+1)'(cnt)) <= (CNT_W+1)'(DEPTH))
    else $error("more beats in flight than queue space");

  a_one_issue: assert property (@(posedge clk) disable iff (rst)
    accept |=> !accept)
    else $error("two samples issued on consecutive cycles");

endmodule
